[rtl/core/assert_macros.svh]
// assertion macros used by the top level rtl file
// no dependencies; empty bodies when SYNTH is defined
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define ASSERT_ALWAYS(lbl, clk, rst_n, expr) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
		else $error("assertion failed");
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
`else
`define ASSERT_ALWAYS(lbl, clk, rst_n, expr)
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons)
`endif
`endif

[rtl/core/spsw_pkg.sv]
// types, constants and the strike pattern function of the sieve window core
// no dependencies
`default_nettype none
package spsw_pkg;
	localparam int NUM_W  = 48;
	localparam int ENT_W  = 24;
	localparam int MASK_W = 64;

	localparam logic [1:0] OP_LOAD  = 2'd0;
	localparam logic [1:0] OP_SIEVE = 2'd1;
	localparam logic [1:0] OP_CLEAR = 2'd2;

	typedef enum logic [2:0] {
		ST_IDLE  = 3'b001,
		ST_ISSUE = 3'b010,
		ST_DRAIN = 3'b100
	} state_t;

	typedef struct packed {
		logic             vld;
		logic [ENT_W-1:0] p;
		logic [ENT_W-1:0] rem;
	} cell_t;

	// bits at 0, p, 2p ... of a 64 bit word, zero for p below two
	function automatic logic [MASK_W-1:0] pat_f(input int p);
		logic [MASK_W-1:0] m;
		int                k;
		m = '0;
		k = 0;
		if (p >= 2) begin
			for (int b = 0; b < MASK_W; b++) begin
				if (k == 0) m[b] = 1'b1;
				k = k + 1;
				if (k == p) k = 0;
			end
		end
		return m;
	endfunction
endpackage
`default_nettype wire

[rtl/core/spsw_ram.sv]
// generic single write, single read ram with registered read data
// no dependencies
`default_nettype none
module spsw_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) mem_q[waddr] <= wdata;
		rdata <= mem_q[raddr];
	end
endmodule
`default_nettype wire

[rtl/core/spsw_cell.sv]
// one restoring remainder step: shifts in one bit of the window start
// depends on spsw_pkg
`default_nettype none
module spsw_cell import spsw_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  cell_t c_in,
	input  logic  dbit,
	output cell_t c_out
);
	logic [ENT_W:0] sh;
	logic [ENT_W:0] dif;

	assign sh  = {c_in.rem, dbit};
	assign dif = sh - {1'b0, c_in.p};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			c_out <= '0;
		end else begin
			c_out.vld <= c_in.vld;
			c_out.p   <= c_in.p;
			c_out.rem <= (sh >= {1'b0, c_in.p}) ? dif[ENT_W-1:0] : sh[ENT_W-1:0];
		end
	end
endmodule
`default_nettype wire

[rtl/core/segmented_prime_sieve_window_core.sv]
// top level of the segmented sieve window core
// depends on spsw_pkg, spsw_ram, spsw_cell and assert_macros.svh
//
//   channel | signals                                    | direction
//   input   | in_valid in_ready opcode operand_value      | in
//   output  | out_valid out_ready prime_mask status_code  | out
//   config  | cfg_we cfg_wdata                            | in
//
// load, clear and unused opcodes give their result in the cycle after they are taken.
// a sieve feeds one table read per cycle into a
// 48 cell remainder chain, then two strike stages and the accumulator.
// no clearing pass after reset; the table is read only where written.
// a result waits in the output register; the next beat is taken with it.
`default_nettype none
`include "assert_macros.svh"
module segmented_prime_sieve_window_core import spsw_pkg::*; #(
	parameter int WINDOW_WIDTH = 64,
	parameter int TABLE_DEPTH  = 4096
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [1:0]        opcode,
	input  logic [NUM_W-1:0]  operand_value,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [MASK_W-1:0] prime_mask,
	output logic              status_code,
	input  logic              cfg_we,
	input  logic [NUM_W-1:0]  cfg_wdata
);
	localparam int AW    = $clog2(TABLE_DEPTH);
	localparam int CW    = $clog2(TABLE_DEPTH + 1);
	localparam int IDX_W = $clog2(WINDOW_WIDTH);

	state_t                  state_q;
	logic [NUM_W-1:0]        cutoff_q;
	logic [CW-1:0]           cnt_q;
	logic [CW-1:0]           rd_ptr_q;
	logic [NUM_W-1:0]        start_q;
	logic [WINDOW_WIDTH-1:0] mask_q;
	logic                    rvld_q;
	logic                    out_valid_q;
	logic [MASK_W-1:0]       prime_mask_q;
	logic                    status_q;

	logic                    in_fire;
	logic                    rd_en;
	logic                    ram_we;
	logic [ENT_W-1:0]        rdata;
	logic                    full;
	logic                    pipe_busy;

	logic [WINDOW_WIDTH-1:0] pat_tab [WINDOW_WIDTH];
	cell_t                   cells [NUM_W+1];
	logic [NUM_W-1:0]        cell_vld;

	logic                    vld_s1;
	logic [ENT_W-1:0]        off_s1;
	logic [NUM_W-1:0]        pp_s1;
	logic [WINDOW_WIDTH-1:0] pat_s1;
	logic                    vld_s2;
	logic [WINDOW_WIDTH-1:0] strike_s2;

	logic [WINDOW_WIDTH-1:0] init_mask;
	logic [NUM_W:0]          cdiff;
	logic [NUM_W:0]          ldiff;
	logic                    cbig;
	logic [WINDOW_WIDTH-1:0] shifted;
	logic [WINDOW_WIDTH-1:0] geq;

	genvar g;
	generate
		for (g = 0; g < WINDOW_WIDTH; g++) begin : g_pat
			assign pat_tab[g] = WINDOW_WIDTH'(pat_f(g));
		end
	endgenerate

	assign in_ready  = (state_q == ST_IDLE) && (!out_valid_q || out_ready);
	assign in_fire   = in_valid && in_ready;
	assign full      = (cnt_q == CW'(TABLE_DEPTH));
	assign ram_we    = in_fire && (opcode == OP_LOAD) && !full;
	assign rd_en     = (state_q == ST_ISSUE) && (rd_ptr_q != cnt_q);
	assign out_valid   = out_valid_q;
	assign prime_mask  = prime_mask_q;
	assign status_code = status_q;

	spsw_ram #(.WIDTH(ENT_W), .DEPTH(TABLE_DEPTH)) u_table (
		.clk   (clk),
		.we    (ram_we),
		.waddr (cnt_q[AW-1:0]),
		.wdata (operand_value[ENT_W-1:0]),
		.raddr (rd_ptr_q[AW-1:0]),
		.rdata (rdata)
	);

	// remainder chain, one start bit per cell, msb first
	assign cells[0] = '{vld: rvld_q, p: rdata, rem: '0};
	generate
		for (g = 0; g < NUM_W; g++) begin : g_cell
			spsw_cell u_cell (
				.clk    (clk),
				.arst_n (arst_n),
				.c_in   (cells[g]),
				.dbit   (start_q[NUM_W-1-g]),
				.c_out  (cells[g+1])
			);
			assign cell_vld[g] = cells[g+1].vld;
		end
	endgenerate

	assign pipe_busy = rvld_q || (|cell_vld) || vld_s1 || vld_s2;

	// window bounds from start and cutoff
	always_comb begin
		cdiff = {1'b0, cutoff_q} - {1'b0, operand_value};
		cbig  = !cdiff[NUM_W] && (cdiff[NUM_W-1:0] >= NUM_W'(WINDOW_WIDTH - 1));
		for (int b = 0; b < WINDOW_WIDTH; b++) begin
			init_mask[b] = !cdiff[NUM_W]
				&& (cbig || (cdiff[IDX_W-1:0] >= IDX_W'(b)))
				&& ((operand_value[NUM_W-1:1] != '0) || (b >= 2)
					|| ((b == 1) && operand_value[0]));
		end
	end

	// strike stages
	always_comb begin
		ldiff = {1'b0, pp_s1} - {1'b0, start_q};
		if (ldiff[NUM_W]) begin
			geq = '1;
		end else if (ldiff[NUM_W-1:0] >= NUM_W'(WINDOW_WIDTH)) begin
			geq = '0;
		end else begin
			geq = {WINDOW_WIDTH{1'b1}} << ldiff[IDX_W-1:0];
		end
		if (off_s1 >= ENT_W'(WINDOW_WIDTH)) begin
			shifted = '0;
		end else begin
			shifted = pat_s1 << off_s1[IDX_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			rvld_q <= 1'b0;
		end else begin
			rvld_q <= rd_en;
			vld_s1 <= cells[NUM_W].vld && (cells[NUM_W].p >= ENT_W'(2));
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		off_s1 <= (cells[NUM_W].rem == '0) ? '0 : (cells[NUM_W].p - cells[NUM_W].rem);
		pp_s1  <= NUM_W'(cells[NUM_W].p) * NUM_W'(cells[NUM_W].p);
		pat_s1 <= (cells[NUM_W].p < ENT_W'(WINDOW_WIDTH))
			? pat_tab[cells[NUM_W].p[IDX_W-1:0]] : WINDOW_WIDTH'(1);
		strike_s2 <= shifted & geq;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cutoff_q    <= {NUM_W{1'b1}};
			cnt_q       <= '0;
			rd_ptr_q    <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) cutoff_q <= cfg_wdata;
			if (out_valid_q && out_ready) out_valid_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (in_fire) begin
						if (opcode == OP_SIEVE) begin
							rd_ptr_q <= '0;
							state_q  <= ST_ISSUE;
						end else begin
							out_valid_q <= 1'b1;
							if (opcode == OP_LOAD && !full) cnt_q <= cnt_q + CW'(1);
							if (opcode == OP_CLEAR) cnt_q <= '0;
						end
					end
				end
				ST_ISSUE: begin
					if (rd_en) rd_ptr_q <= rd_ptr_q + CW'(1);
					else state_q <= ST_DRAIN;
				end
				ST_DRAIN: begin
					if (!pipe_busy) begin
						out_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			prime_mask_q <= '0;
			status_q     <= (opcode == OP_LOAD) && full;
			if (opcode == OP_SIEVE) begin
				start_q <= operand_value;
				mask_q  <= init_mask;
			end
		end else begin
			if (vld_s2) mask_q <= mask_q & ~strike_s2;
			if (state_q == ST_DRAIN && !pipe_busy) begin
				prime_mask_q <= MASK_W'(mask_q);
				status_q     <= 1'b0;
			end
		end
	end

	`ASSERT_ALWAYS(a_cnt_max, clk, arst_n, cnt_q <= CW'(TABLE_DEPTH))
	`ASSERT_IMPL(a_ready_idle, clk, arst_n, in_ready, state_q == ST_IDLE)
	`ASSERT_IMPL(a_status_mask, clk, arst_n, out_valid && status_code, prime_mask == '0)
endmodule
`default_nettype wire
